### src/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Widths, register indexes and the square-root cell record shared by the
// ray-sphere intersection core.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int CoordW    = 24;
  localparam int DirW      = 16;
  localparam int RadiusW   = 23;
  localparam int DeltaW    = CoordW + 1;
  localparam int DirFrac   = 14;
  localparam int DotPW     = DeltaW + DirW;
  localparam int DotW      = DotPW + 2;
  localparam int BW        = DotW - DirFrac;
  localparam int SqW       = 2 * DeltaW;
  localparam int RrW       = 2 * RadiusW;
  localparam int CW        = SqW + 2;
  localparam int BbW       = 2 * BW;
  localparam int DqW       = BbW + 1;
  localparam int RadicandW = BbW;
  localparam int RootW     = RadicandW / 2;
  localparam int RemW      = RootW + 3;
  localparam int NegBW     = BW + 1;
  localparam int TW        = NegBW + 1;
  localparam int DistW     = 24;

  localparam int CfgIdxW   = 8;
  localparam int CfgDataW  = CoordW;

  localparam int FrontStages = 5;
  localparam int Latency     = FrontStages + RootW + 1;

  localparam logic [CfgIdxW-1:0] RegCenterX = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegCenterY = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegCenterZ = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegRadius  = CfgIdxW'(3);

  typedef struct packed {
    logic                    miss;
    logic signed [NegBW-1:0] neg_b;
    logic [RadicandW-1:0]    rad;
    logic [RemW-1:0]         rem;
    logic [RootW-1:0]        root;
  } sqrt_cell_t;

endpackage

### src/rsi_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rsi_sqrt_cell
// One digit cell of the square-root chain: takes the next two radicand bits,
// decides one root bit and hands the partial result to the next cell.
// ----------------------------------------------------------------------------
module rsi_sqrt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  rsi_pkg::sqrt_cell_t cell_i,
  output logic                valid_o,
  output rsi_pkg::sqrt_cell_t cell_o
);

  logic [rsi_pkg::RemW-1:0] rem_shift;
  logic [rsi_pkg::RemW-1:0] trial;
  logic                     ge;
  rsi_pkg::sqrt_cell_t      cell_d;
  rsi_pkg::sqrt_cell_t      cell_q;
  logic                     valid_q;

  always_comb begin
    rem_shift = {cell_i.rem[rsi_pkg::RemW-3:0],
                 cell_i.rad[rsi_pkg::RadicandW-1 -: 2]};
    trial     = rsi_pkg::RemW'({cell_i.root, 2'b01});
    ge        = (rem_shift >= trial);
    cell_d       = cell_i;
    cell_d.rad   = cell_i.rad << 2;
    cell_d.root  = {cell_i.root[rsi_pkg::RootW-2:0], ge};
    cell_d.rem   = ge ? (rem_shift - trial) : rem_shift;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

### src/rsi_quad_front.sv
// ----------------------------------------------------------------------------
// rsi_quad_front
// Five-stage front end: offset from the centre, products, dot product and
// squared length, b squared, and the quarter discriminant that seeds the
// square-root chain.
// ----------------------------------------------------------------------------
module rsi_quad_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [rsi_pkg::CoordW-1:0]   origin_x_i,
  input  logic signed [rsi_pkg::CoordW-1:0]   origin_y_i,
  input  logic signed [rsi_pkg::CoordW-1:0]   origin_z_i,
  input  logic signed [rsi_pkg::DirW-1:0]     dir_x_i,
  input  logic signed [rsi_pkg::DirW-1:0]     dir_y_i,
  input  logic signed [rsi_pkg::DirW-1:0]     dir_z_i,
  input  logic signed [rsi_pkg::CoordW-1:0]   center_x_i,
  input  logic signed [rsi_pkg::CoordW-1:0]   center_y_i,
  input  logic signed [rsi_pkg::CoordW-1:0]   center_z_i,
  input  logic        [rsi_pkg::RadiusW-1:0]  sphere_radius_i,
  output logic                                valid_o,
  output rsi_pkg::sqrt_cell_t                 seed_o
);

  logic [rsi_pkg::FrontStages-1:0] vld_q;

  // stage 1
  logic signed [rsi_pkg::DeltaW-1:0] dx_q, dy_q, dz_q;
  logic signed [rsi_pkg::DirW-1:0]   ux_q, uy_q, uz_q;
  // stage 2
  logic signed [rsi_pkg::DotPW-1:0]  pdx_q, pdy_q, pdz_q;
  logic signed [rsi_pkg::SqW-1:0]    sqx_q, sqy_q, sqz_q;
  logic        [rsi_pkg::RrW-1:0]    rr_q;
  // stage 3
  logic signed [rsi_pkg::DotW-1:0]   dot;
  logic signed [rsi_pkg::BW-1:0]     b3_q;
  logic signed [rsi_pkg::CW-1:0]     c3_q;
  // stage 4
  logic signed [rsi_pkg::BbW-1:0]    bb_q;
  logic signed [rsi_pkg::BW-1:0]     b4_q;
  logic signed [rsi_pkg::CW-1:0]     c4_q;
  // stage 5
  logic signed [rsi_pkg::DqW-1:0]    dq;
  rsi_pkg::sqrt_cell_t               seed_d;
  rsi_pkg::sqrt_cell_t               seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[rsi_pkg::FrontStages-2:0], valid_i};
    end
  end

  assign dot = rsi_pkg::DotW'(pdx_q) + rsi_pkg::DotW'(pdy_q) + rsi_pkg::DotW'(pdz_q);

  // quarter discriminant, miss flag, clamped radicand and negated b for the seed
  always_comb begin
    dq = rsi_pkg::DqW'(bb_q) - rsi_pkg::DqW'(c4_q);
    seed_d.miss  = dq[rsi_pkg::DqW-1];
    seed_d.rad   = dq[rsi_pkg::DqW-1] ? '0 : dq[rsi_pkg::RadicandW-1:0];
    seed_d.neg_b = -rsi_pkg::NegBW'(b4_q);
    seed_d.rem   = '0;
    seed_d.root  = '0;
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= rsi_pkg::DeltaW'(origin_x_i) - rsi_pkg::DeltaW'(center_x_i);
    dy_q  <= rsi_pkg::DeltaW'(origin_y_i) - rsi_pkg::DeltaW'(center_y_i);
    dz_q  <= rsi_pkg::DeltaW'(origin_z_i) - rsi_pkg::DeltaW'(center_z_i);
    ux_q  <= dir_x_i;
    uy_q  <= dir_y_i;
    uz_q  <= dir_z_i;

    pdx_q <= rsi_pkg::DotPW'(dx_q) * rsi_pkg::DotPW'(ux_q);
    pdy_q <= rsi_pkg::DotPW'(dy_q) * rsi_pkg::DotPW'(uy_q);
    pdz_q <= rsi_pkg::DotPW'(dz_q) * rsi_pkg::DotPW'(uz_q);
    sqx_q <= rsi_pkg::SqW'(dx_q) * rsi_pkg::SqW'(dx_q);
    sqy_q <= rsi_pkg::SqW'(dy_q) * rsi_pkg::SqW'(dy_q);
    sqz_q <= rsi_pkg::SqW'(dz_q) * rsi_pkg::SqW'(dz_q);
    rr_q  <= rsi_pkg::RrW'(sphere_radius_i) * rsi_pkg::RrW'(sphere_radius_i);

    b3_q  <= rsi_pkg::BW'(dot >>> rsi_pkg::DirFrac);
    c3_q  <= rsi_pkg::CW'(sqx_q) + rsi_pkg::CW'(sqy_q) + rsi_pkg::CW'(sqz_q)
             - rsi_pkg::CW'($signed({1'b0, rr_q}));

    bb_q  <= rsi_pkg::BbW'(b3_q) * rsi_pkg::BbW'(b3_q);
    b4_q  <= b3_q;
    c4_q  <= c3_q;

    seed_q <= seed_d;
  end

  assign valid_o = vld_q[rsi_pkg::FrontStages-1];
  assign seed_o  = seed_q;

endmodule

### src/ray_sphere_intersection_core.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersection_core
// Tests one ray per clock against a configured sphere and reports the near
// intersection distance, or a miss.
// ----------------------------------------------------------------------------
// A ray is taken at every clock edge where start is high; busy stays low, so
// one ray per cycle is accepted. Each ray gives one result, shown on hit_o and
// distance_o for the single cycle in which valid_o is high, in the order the
// rays came in; the receiver cannot stall the block. The pipeline is five
// front stages (offset, products, sums, b squared, discriminant), a chain of
// 29 square-root cells taking one root bit each, and the output register.
// Sphere registers are written through the always-ready cfg channel; the user
// must do so only while no ray is in flight, which the block does not enforce.
module ray_sphere_intersection_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [rsi_pkg::CoordW-1:0]    origin_x_i,
  input  logic signed [rsi_pkg::CoordW-1:0]    origin_y_i,
  input  logic signed [rsi_pkg::CoordW-1:0]    origin_z_i,
  input  logic signed [rsi_pkg::DirW-1:0]      dir_x_i,
  input  logic signed [rsi_pkg::DirW-1:0]      dir_y_i,
  input  logic signed [rsi_pkg::DirW-1:0]      dir_z_i,
  output logic                                 valid_o,
  output logic                                 hit_o,
  output logic        [rsi_pkg::DistW-1:0]     distance_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [rsi_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic        [rsi_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic signed [rsi_pkg::CoordW-1:0]  center_x_q, center_y_q, center_z_q;
  logic        [rsi_pkg::RadiusW-1:0] radius_q;

  logic                               accept;
  logic                               chain_vld [rsi_pkg::RootW+1];
  rsi_pkg::sqrt_cell_t                chain     [rsi_pkg::RootW+1];

  logic signed [rsi_pkg::TW-1:0]      t;
  logic                               hit_d;
  logic        [rsi_pkg::DistW-1:0]   dist_d;
  logic                               valid_q;
  logic                               hit_q;
  logic        [rsi_pkg::DistW-1:0]   dist_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start & ~busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
      radius_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rsi_pkg::RegCenterX: center_x_q <= cfg_data_i;
        rsi_pkg::RegCenterY: center_y_q <= cfg_data_i;
        rsi_pkg::RegCenterZ: center_z_q <= cfg_data_i;
        rsi_pkg::RegRadius:  radius_q   <= cfg_data_i[rsi_pkg::RadiusW-1:0];
        default: ;
      endcase
    end
  end

  rsi_quad_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (accept),
    .origin_x_i      (origin_x_i),
    .origin_y_i      (origin_y_i),
    .origin_z_i      (origin_z_i),
    .dir_x_i         (dir_x_i),
    .dir_y_i         (dir_y_i),
    .dir_z_i         (dir_z_i),
    .center_x_i      (center_x_q),
    .center_y_i      (center_y_q),
    .center_z_i      (center_z_q),
    .sphere_radius_i (radius_q),
    .valid_o         (chain_vld[0]),
    .seed_o          (chain[0])
  );

  for (genvar k = 0; k < rsi_pkg::RootW; k++) begin : g_cell
    rsi_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_vld[k]),
      .cell_i  (chain[k]),
      .valid_o (chain_vld[k+1]),
      .cell_o  (chain[k+1])
    );
  end

  // near root and saturation
  always_comb begin
    t      = rsi_pkg::TW'(chain[rsi_pkg::RootW].neg_b)
             - rsi_pkg::TW'($signed({1'b0, chain[rsi_pkg::RootW].root}));
    hit_d  = ~chain[rsi_pkg::RootW].miss & ~t[rsi_pkg::TW-1];
    dist_d = '0;
    if (hit_d) begin
      dist_d = (|t[rsi_pkg::TW-2:rsi_pkg::DistW]) ? '1 : t[rsi_pkg::DistW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
      dist_q  <= '0;
    end else begin
      valid_q <= chain_vld[rsi_pkg::RootW];
      if (chain_vld[rsi_pkg::RootW]) begin
        hit_q  <= hit_d;
        dist_q <= dist_d;
      end
    end
  end

  assign valid_o    = valid_q;
  assign hit_o      = hit_q;
  assign distance_o = dist_q;

endmodule

### src/rsi_checker.sv
// ----------------------------------------------------------------------------
// rsi_checker
// Port-level checks of the intersection core: fixed latency from start to
// result, miss encoding and result hold between transactions.
// ----------------------------------------------------------------------------
module rsi_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic                             valid_o,
  input logic                             hit_o,
  input logic [rsi_pkg::DistW-1:0]        distance_o
);

  localparam int CntW = $clog2(rsi_pkg::Latency + 1);

  logic [CntW-1:0] cnt_q;
  logic            warm;
  logic            accept;

  assign accept = start & ~busy;
  assign warm   = (cnt_q == CntW'(rsi_pkg::Latency));

  // cycles since reset release, held once warm
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (!warm) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  a_result_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warm && valid_o |-> $past(accept, rsi_pkg::Latency))
    else $error("result without matching transaction");

  a_request_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warm && $past(accept, rsi_pkg::Latency) |-> valid_o)
    else $error("transaction lost");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !hit_o |-> distance_o == '0)
    else $error("miss with non-zero distance");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && !valid_o |-> $stable(hit_o) && $stable(distance_o))
    else $error("result ports changed without a transaction");

endmodule

bind ray_sphere_intersection_core rsi_checker u_rsi_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .valid_o    (valid_o),
  .hit_o      (hit_o),
  .distance_o (distance_o)
);

### dv/ray_sphere_intersection_core_tb.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersection_core_tb
// Streams rays into the core and checks every hit flag and distance against
// a fixed-point predictor of the near-root sphere test. The sphere
// registers are reprogrammed between phases. The ray mix is directed corners,
// then aimed, receding, inside and unconstrained rays, under varying gaps.
// ----------------------------------------------------------------------------
module ray_sphere_intersection_core_tb;

  localparam logic signed [rsi_pkg::CoordW-1:0] MinCoord =
    {1'b1, {(rsi_pkg::CoordW-1){1'b0}}};
  localparam logic signed [rsi_pkg::CoordW-1:0] MaxCoord =
    {1'b0, {(rsi_pkg::CoordW-1){1'b1}}};
  localparam logic        [rsi_pkg::RadiusW-1:0] MaxRadius = {rsi_pkg::RadiusW{1'b1}};
  localparam logic signed [rsi_pkg::DirW-1:0]    DirOne    = rsi_pkg::DirW'(16384);
  localparam logic [rsi_pkg::CfgIdxW-1:0] RegSpare   = rsi_pkg::CfgIdxW'(4);
  localparam logic [rsi_pkg::CfgIdxW-1:0] RegTopIdx  = {rsi_pkg::CfgIdxW{1'b1}};
  localparam longint DistMax     = (longint'(1) << rsi_pkg::DistW) - 1;
  localparam int     CycleLimit  = 200000;
  localparam int     RaysPerPhase = 275;

  typedef struct packed {
    logic signed [rsi_pkg::CoordW-1:0] origin_x;
    logic signed [rsi_pkg::CoordW-1:0] origin_y;
    logic signed [rsi_pkg::CoordW-1:0] origin_z;
    logic signed [rsi_pkg::DirW-1:0]   dir_x;
    logic signed [rsi_pkg::DirW-1:0]   dir_y;
    logic signed [rsi_pkg::DirW-1:0]   dir_z;
  } ray_t;

  typedef struct packed {
    logic                      hit;
    logic [rsi_pkg::DistW-1:0] distance;
  } result_t;

  typedef enum int {AimAt, AimAway, AimInside} aim_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [rsi_pkg::CoordW-1:0] origin_x_i = '0;
  logic signed [rsi_pkg::CoordW-1:0] origin_y_i = '0;
  logic signed [rsi_pkg::CoordW-1:0] origin_z_i = '0;
  logic signed [rsi_pkg::DirW-1:0]   dir_x_i = '0;
  logic signed [rsi_pkg::DirW-1:0]   dir_y_i = '0;
  logic signed [rsi_pkg::DirW-1:0]   dir_z_i = '0;
  logic                              valid_o;
  logic                              hit_o;
  logic [rsi_pkg::DistW-1:0]         distance_o;
  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  logic [rsi_pkg::CfgIdxW-1:0]       cfg_index_i = '0;
  logic [rsi_pkg::CfgDataW-1:0]      cfg_data_i = '0;

  // sphere as programmed into the core
  logic signed [rsi_pkg::CoordW-1:0] sphere_cx = '0;
  logic signed [rsi_pkg::CoordW-1:0] sphere_cy = '0;
  logic signed [rsi_pkg::CoordW-1:0] sphere_cz = '0;
  logic        [rsi_pkg::RadiusW-1:0] sphere_r = '0;

  ray_t    pending_rays[$];
  result_t predicted_hits[$];
  int      rays_queued = 0;
  int      rays_accepted = 0;
  int      errors = 0;
  int      cycle_count = 0;
  int unsigned sender_idle_pct = 15;

  ray_sphere_intersection_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .origin_x_i  (origin_x_i),
    .origin_y_i  (origin_y_i),
    .origin_z_i  (origin_z_i),
    .dir_x_i     (dir_x_i),
    .dir_y_i     (dir_y_i),
    .dir_z_i     (dir_z_i),
    .valid_o     (valid_o),
    .hit_o       (hit_o),
    .distance_o  (distance_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned rem = v;
    longint unsigned root = 0;
    longint unsigned pos = longint'(1) << 62;
    while (pos > v) pos >>= 2;
    while (pos != 0) begin
      if (rem >= root + pos) begin
        rem  = rem - (root + pos);
        root = (root >> 1) + pos;
      end else begin
        root = root >> 1;
      end
      pos >>= 2;
    end
    return root;
  endfunction

  // near-root intersection in the core's fixed-point formats
  function automatic result_t trace_ray(ray_t r);
    longint dx, dy, dz, ux, uy, uz, b, c, dq, t, rr;
    result_t res;
    dx = longint'($signed(r.origin_x)) - longint'($signed(sphere_cx));
    dy = longint'($signed(r.origin_y)) - longint'($signed(sphere_cy));
    dz = longint'($signed(r.origin_z)) - longint'($signed(sphere_cz));
    ux = longint'($signed(r.dir_x));
    uy = longint'($signed(r.dir_y));
    uz = longint'($signed(r.dir_z));
    rr = longint'(sphere_r);
    b  = (dx * ux + dy * uy + dz * uz) >>> rsi_pkg::DirFrac;
    c  = dx * dx + dy * dy + dz * dz - rr * rr;
    dq = b * b - c;
    res = '0;
    if (dq >= 0) begin
      t = -b - longint'(floor_sqrt(longint'(dq)));
      if (t >= 0) begin
        res.hit      = 1'b1;
        res.distance = (t > DistMax) ? rsi_pkg::DistW'(DistMax) : rsi_pkg::DistW'(t);
      end
    end
    return res;
  endfunction

  function automatic real rnd_sym();
    return real'($urandom_range(0, 2000000)) / 1.0e6 - 1.0;
  endfunction

  function automatic real rnd_pos();
    return real'($urandom_range(0, 1000000)) / 1.0e6;
  endfunction

  function automatic logic signed [rsi_pkg::CoordW-1:0] to_coord(real v);
    if (v > 8388607.0) return MaxCoord;
    if (v < -8388608.0) return MinCoord;
    return rsi_pkg::CoordW'(longint'(v));
  endfunction

  task automatic queue_ray(ray_t r);
    pending_rays.push_back(r);
    rays_queued++;
  endtask

  // ray built around the programmed sphere: towards it, away from it, or inside
  task automatic queue_aimed_ray(aim_e aim);
    real ux, uy, uz, n, wx, wy, wz, wd, wn, k, s, rr;
    ray_t r;
    do begin
      ux = rnd_sym();
      uy = rnd_sym();
      uz = rnd_sym();
      n  = $sqrt(ux * ux + uy * uy + uz * uz);
    end while (n < 0.1 || n > 1.0);
    ux = ux / n;
    uy = uy / n;
    uz = uz / n;
    wx = rnd_sym();
    wy = rnd_sym();
    wz = rnd_sym();
    wd = wx * ux + wy * uy + wz * uz;
    wx = wx - wd * ux;
    wy = wy - wd * uy;
    wz = wz - wd * uz;
    wn = $sqrt(wx * wx + wy * wy + wz * wz);
    if (wn < 1.0e-6) wn = 1.0;
    rr = real'(sphere_r);
    k  = (aim == AimInside) ? 0.9 * rnd_pos() : 1.3 * rnd_pos();
    wx = wx / wn * rr * k;
    wy = wy / wn * rr * k;
    wz = wz / wn * rr * k;
    if (aim == AimInside) s = 0.0;
    else s = rr * (1.0 + rnd_pos()) + real'($urandom_range(0, 4194304));
    if (aim == AimAt) s = -s;
    r.origin_x = to_coord(real'($signed(sphere_cx)) + wx + ux * s);
    r.origin_y = to_coord(real'($signed(sphere_cy)) + wy + uy * s);
    r.origin_z = to_coord(real'($signed(sphere_cz)) + wz + uz * s);
    r.dir_x    = rsi_pkg::DirW'(longint'(ux * 16384.0));
    r.dir_y    = rsi_pkg::DirW'(longint'(uy * 16384.0));
    r.dir_z    = rsi_pkg::DirW'(longint'(uz * 16384.0));
    queue_ray(r);
  endtask

  task automatic write_reg(logic [rsi_pkg::CfgIdxW-1:0] idx,
                           logic [rsi_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_sphere(logic [rsi_pkg::CfgDataW-1:0] cx,
                              logic [rsi_pkg::CfgDataW-1:0] cy,
                              logic [rsi_pkg::CfgDataW-1:0] cz,
                              logic [rsi_pkg::RadiusW-1:0] r);
    write_reg(rsi_pkg::RegCenterX, cx);
    write_reg(rsi_pkg::RegCenterY, cy);
    write_reg(rsi_pkg::RegCenterZ, cz);
    write_reg(rsi_pkg::RegRadius, rsi_pkg::CfgDataW'(r));
  endtask

  task automatic wait_drained();
    wait (rays_accepted == rays_queued && predicted_hits.size() == 0);
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rsi_pkg::RegCenterX: sphere_cx <= cfg_data_i;
        rsi_pkg::RegCenterY: sphere_cy <= cfg_data_i;
        rsi_pkg::RegCenterZ: sphere_cz <= cfg_data_i;
        rsi_pkg::RegRadius:  sphere_r  <= cfg_data_i[rsi_pkg::RadiusW-1:0];
        default: ;
      endcase
    end
  end

  // ray driver
  always @(posedge clk_i or negedge rst_ni) begin
    ray_t nr;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predicted_hits.push_back(trace_ray(ray_t'{origin_x_i, origin_y_i, origin_z_i,
                                                  dir_x_i, dir_y_i, dir_z_i}));
        rays_accepted++;
      end
      if (!start || !busy) begin
        if (pending_rays.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          nr = pending_rays.pop_front();
          start      <= 1'b1;
          origin_x_i <= nr.origin_x;
          origin_y_i <= nr.origin_y;
          origin_z_i <= nr.origin_z;
          dir_x_i    <= nr.dir_x;
          dir_y_i    <= nr.dir_y;
          dir_z_i    <= nr.dir_z;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && valid_o) begin
      if (predicted_hits.size() == 0) begin
        $display("%0t: unexpected result, expected none, got hit %0b distance %0d",
                 $time, hit_o, distance_o);
        errors++;
      end else begin
        want = predicted_hits.pop_front();
        if (hit_o !== want.hit) begin
          $display("%0t: hit mismatch, expected %0b, got %0b", $time, want.hit, hit_o);
          errors++;
        end
        if (distance_o !== want.distance) begin
          $display("%0t: distance mismatch, expected %0d, got %0d",
                   $time, want.distance, distance_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int pick;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sphere at reset: zero radius at the origin
    queue_ray(ray_t'{24'sd0, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 16'sd0});
    queue_ray(ray_t'{24'sd0, 24'sd0, -24'sd2560, 16'sd0, 16'sd0, DirOne});
    queue_ray(ray_t'{MaxCoord, MaxCoord, MaxCoord, -DirOne, -DirOne, -DirOne});
    queue_ray(ray_t'{MinCoord, MinCoord, MinCoord, DirOne, DirOne, DirOne});
    queue_ray(ray_t'{MinCoord, MaxCoord, 24'sd0, -16'sd1, 16'sd1, 16'sd0});
    wait_drained();

    // huge sphere in the far corner, long distances saturate
    write_sphere(MaxCoord, MaxCoord, MaxCoord, MaxRadius);
    queue_ray(ray_t'{MinCoord, MinCoord, MinCoord, 16'sd9459, 16'sd9459, 16'sd9459});
    queue_ray(ray_t'{MaxCoord, MaxCoord, MaxCoord, DirOne, 16'sd0, 16'sd0});
    queue_ray(ray_t'{MinCoord, MinCoord, MinCoord, -DirOne, 16'sd0, 16'sd0});
    queue_ray(ray_t'{MinCoord, MaxCoord, MaxCoord, DirOne, 16'sd0, 16'sd0});
    wait_drained();

    // writes to unused indexes must leave the sphere alone
    write_reg(RegSpare, rsi_pkg::CfgDataW'($urandom));
    write_reg(RegTopIdx, rsi_pkg::CfgDataW'($urandom));
    write_sphere(MinCoord, MinCoord, MinCoord, rsi_pkg::RadiusW'(2560));
    write_reg(RegSpare, rsi_pkg::CfgDataW'($urandom));
    queue_ray(ray_t'{MinCoord, MinCoord, MinCoord + 24'sd25600, 16'sd0, 16'sd0, -DirOne});
    queue_ray(ray_t'{MinCoord + 24'sd25600, MinCoord, MinCoord, -DirOne, 16'sd0, 16'sd0});
    queue_ray(ray_t'{MinCoord, MinCoord + 24'sd5000, MinCoord + 24'sd25600,
                     16'sd0, 16'sd0, -DirOne});
    queue_ray(ray_t'{MinCoord, MinCoord + 24'sd2560, MinCoord + 24'sd25600,
                     16'sd0, 16'sd0, -DirOne});
    queue_ray(ray_t'{MinCoord, MinCoord, MinCoord + 24'sd25600, 16'sd0, 16'sd0, DirOne});
    queue_ray(ray_t'{MinCoord, MinCoord, MinCoord + 24'sd25600, 16'sd0, 16'sd0, -16'sd8192});
    queue_ray(ray_t'{MinCoord + 24'sd100, MinCoord + 24'sd100, MinCoord,
                     16'sd0, -DirOne, 16'sd0});
    queue_ray(ray_t'{MinCoord, MinCoord, MinCoord, DirOne, DirOne, DirOne});
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      sender_idle_pct = (p < 2) ? 15 : (p < 4) ? 69 : 0;
      case (p)
        1: write_sphere(MinCoord, MinCoord, MinCoord,
                        rsi_pkg::RadiusW'($urandom_range(0, 65536)));
        2: write_sphere(MaxCoord, MaxCoord, MaxCoord, MaxRadius);
        3: write_sphere(rsi_pkg::CfgDataW'($urandom), rsi_pkg::CfgDataW'($urandom),
                        rsi_pkg::CfgDataW'($urandom), rsi_pkg::RadiusW'($urandom));
        default: write_sphere(rsi_pkg::CfgDataW'($urandom_range(0, 1 << 23) - (1 << 22)),
                              rsi_pkg::CfgDataW'($urandom_range(0, 1 << 23) - (1 << 22)),
                              rsi_pkg::CfgDataW'($urandom_range(0, 1 << 23) - (1 << 22)),
                              rsi_pkg::RadiusW'($urandom_range(0, 1 << 21)));
      endcase
      for (int i = 0; i < RaysPerPhase; i++) begin
        pick = $urandom_range(99);
        if (pick < 55) queue_aimed_ray(AimAt);
        else if (pick < 70) queue_aimed_ray(AimAway);
        else if (pick < 80) queue_aimed_ray(AimInside);
        else queue_ray(ray_t'{rsi_pkg::CoordW'($urandom), rsi_pkg::CoordW'($urandom),
                              rsi_pkg::CoordW'($urandom),
                              rsi_pkg::DirW'($urandom_range(0, 32768) - 16384),
                              rsi_pkg::DirW'($urandom_range(0, 32768) - 16384),
                              rsi_pkg::DirW'($urandom_range(0, 32768) - 16384)});
      end
      wait_drained();
    end

    repeat (rsi_pkg::Latency + 4) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### ray_sphere_intersection_core.f
src/rsi_pkg.sv
src/rsi_sqrt_cell.sv
src/rsi_quad_front.sv
src/ray_sphere_intersection_core.sv
src/rsi_checker.sv
dv/ray_sphere_intersection_core_tb.sv
